### rtl/binary_trie_prefix_match_macros.svh
// Assertion macros shared by the trie prefix match checker.
`ifndef BINARY_TRIE_PREFIX_MATCH_MACROS_SVH
`define BINARY_TRIE_PREFIX_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTPM_ASSERT_IMPL(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define BTPM_ASSERT_NEXT(lbl, clk, a, b, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error(msg);

`endif

### rtl/btpm_pkg.sv
// Shared types and constants of the binary trie prefix match block.
package btpm_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int ADDR_BITS_DEF  = 128;
  localparam int ADDR_MAX       = 128;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] match_len;
    logic       status;
  } out_item_t;

  // One classified command waiting for the walker.
  typedef struct packed {
    logic                kind;
    logic                zero;
    logic [7:0]          steps;
    logic [ADDR_MAX-1:0] addr;
  } cmd_t;

endpackage

### rtl/btpm_front.sv
// Command intake: classifies each command and queues it for the walker.
module btpm_front
  import btpm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  logic [ADDR_MAX-1:0] addr_full;
  logic [ADDR_MAX-1:0] addr_walked;
  cmd_t                cmd_nxt;
  logic                push;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign addr_full   = {in_item.addr_high, in_item.addr_low};
  assign addr_walked = addr_full >> (ADDR_MAX - ADDR_BITS);

  always_comb begin
    cmd_nxt.kind = in_item.kind;
    cmd_nxt.zero = (addr_walked == '0);
    cmd_nxt.addr = addr_full;
    if (in_item.prefix_len > 8'(ADDR_BITS)) begin
      cmd_nxt.steps = 8'(ADDR_BITS);
    end else begin
      cmd_nxt.steps = in_item.prefix_len;
    end
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/btpm_back.sv
// Trie walker: node memory, root node, allocation counter and result register.
module btpm_back
  import btpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int UW = $clog2(NODE_COUNT + 1);
  localparam int PW = $clog2(ADDR_BITS + 1);
  localparam int NW = 2 * IW + 1;

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  // A node is {end mark, child one, child zero}; a zero link means no child.
  logic [NW-1:0] mem [NODE_COUNT];
  logic [NW-1:0] rdata_r;

  state_t              state_r;
  logic [NW-1:0]       root_r;
  logic [UW-1:0]       used_r;
  logic [IW-1:0]       cur_r;
  logic [NW-1:0]       node_r;
  logic                src_mem_r;
  logic [PW-1:0]       pos_r;
  logic [PW-1:0]       best_r;
  logic [7:0]          steps_r;
  logic [ADDR_MAX-1:0] addr_r;
  logic                kind_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic [NW-1:0] cur_node;
  logic          bit_b;
  logic [IW-1:0] nxt_idx;
  logic [IW-1:0] new_idx;
  logic [PW-1:0] best_now;
  logic          pool_full;
  logic          advance;
  logic          create;
  logic          finish;
  logic          fin_status;
  logic          wen;
  logic [NW-1:0] wnode;
  logic          wr_root;
  logic          wr_mem;

  assign cur_node  = src_mem_r ? rdata_r : node_r;
  assign bit_b     = addr_r[ADDR_MAX-1];
  assign nxt_idx   = bit_b ? cur_node[2*IW-1:IW] : cur_node[IW-1:0];
  assign new_idx   = used_r[IW-1:0];
  assign pool_full = (used_r == UW'(NODE_COUNT));
  // The root sits at depth zero, so its mark is never reported.
  assign best_now  = (cur_node[NW-1] && (pos_r != '0)) ? pos_r : best_r;

  always_comb begin
    advance    = 1'b0;
    create     = 1'b0;
    finish     = 1'b0;
    fin_status = STATUS_DONE;
    wen        = 1'b0;
    wnode      = cur_node;
    if (state_r == ST_WALK) begin
      if (kind_r == KIND_INSERT) begin
        if (8'(pos_r) == steps_r) begin
          finish       = 1'b1;
          wen          = 1'b1;
          wnode[NW-1]  = 1'b1;
        end else if (nxt_idx != '0) begin
          advance = 1'b1;
        end else if (pool_full) begin
          // Write the node back so that a freshly linked node is cleared.
          finish     = 1'b1;
          fin_status = STATUS_FULL;
          wen        = 1'b1;
        end else begin
          create = 1'b1;
          wen    = 1'b1;
          if (bit_b) begin
            wnode[2*IW-1:IW] = new_idx;
          end else begin
            wnode[IW-1:0] = new_idx;
          end
        end
      end else begin
        if ((pos_r == PW'(ADDR_BITS)) || (nxt_idx == '0)) begin
          finish = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
    end
  end

  assign wr_root = wen && (cur_r == '0);
  assign wr_mem  = wen && (cur_r != '0);
  assign q_pop   = (state_r == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (wr_mem) begin
      mem[cur_r] <= wnode;
    end
    if (advance) begin
      rdata_r <= mem[nxt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      used_r      <= UW'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (wr_root) begin
        root_r <= wnode;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.zero) begin
              out_valid_r          <= 1'b1;
              out_item_r.match_len <= 8'd0;
              out_item_r.status    <= STATUS_DONE;
            end else begin
              state_r   <= ST_WALK;
              kind_r    <= q_cmd.kind;
              steps_r   <= q_cmd.steps;
              addr_r    <= q_cmd.addr;
              cur_r     <= '0;
              node_r    <= root_r;
              src_mem_r <= 1'b0;
              pos_r     <= '0;
              best_r    <= '0;
            end
          end
        end
        ST_WALK: begin
          if (finish) begin
            state_r           <= ST_IDLE;
            out_valid_r       <= 1'b1;
            out_item_r.status <= fin_status;
            if (kind_r == KIND_LOOKUP) begin
              out_item_r.match_len <= 8'(best_now);
            end else begin
              out_item_r.match_len <= 8'd0;
            end
          end
          if (advance) begin
            cur_r     <= nxt_idx;
            src_mem_r <= 1'b1;
            pos_r     <= pos_r + PW'(1);
            addr_r    <= {addr_r[ADDR_MAX-2:0], 1'b0};
            best_r    <= best_now;
          end
          if (create) begin
            cur_r     <= new_idx;
            node_r    <= '0;
            src_mem_r <= 1'b0;
            used_r    <= used_r + UW'(1);
            pos_r     <= pos_r + PW'(1);
            addr_r    <= {addr_r[ADDR_MAX-2:0], 1'b0};
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/binary_trie_prefix_match.sv
// Each accepted command yields one result strobe; an all-zero address is answered without a walk.
// Others walk up to ADDR_BITS trie levels; each step over an existing link reads one memory node.
// The walker pops a new command only when idle, so it takes none before the last walk is done.
// Two commands may queue while the walker is busy; busy rises only when both slots are full.
// Synchronous reset empties the queue, clears the root node and sets the node count to one.
// Results cannot be stalled; out_valid marks each for exactly one cycle.
module binary_trie_prefix_match
  import btpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // The front end turns each transfer into a walk command: the number of
  // insert steps is saturated to the address width, and an address whose
  // walked bits are all zero is flagged so that it produces a plain result.
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  btpm_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // The back end walks the trie one level per cycle. The root node lives in
  // flops; all other nodes live in a memory, and each new node is written in
  // full when the walk steps onto it, so no entry is read before it is written.
  btpm_back #(
    .NODE_COUNT(NODE_COUNT),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### rtl/btpm_checker.sv
// Port-level checker for the trie prefix match block, bound to its top level.
`include "binary_trie_prefix_match_macros.svh"

module btpm_checker
  import btpm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // A full node pool can only be reported by an insert, which never matches.
  `BTPM_ASSERT_IMPL(a_full_no_match, clk, rst_n,
    out_valid && (out_item.status == STATUS_FULL), out_item.match_len == 8'd0,
    "full status with a nonzero match length")

  // No stored prefix can be longer than the walked address.
  `BTPM_ASSERT_IMPL(a_match_range, clk, rst_n,
    out_valid, out_item.match_len <= 8'(ADDR_BITS), "match length beyond address width")

  // Reset leaves an empty queue and no pending result.
  `BTPM_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid && !busy, "activity right after reset")

endmodule

bind binary_trie_prefix_match btpm_checker #(
  .ADDR_BITS(ADDR_BITS)
) u_btpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

### dv/trie_match_checker.sv
// Checker for the binary trie prefix match block: trie predictor and result comparison.
module trie_match_checker
  import btpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  output int unsigned mismatches,
  output int unsigned answers_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow trie. A link of zero means no child, since the root is never a child.
  int unsigned zero_link [NODE_COUNT];
  int unsigned one_link  [NODE_COUNT];
  bit          prefix_end[NODE_COUNT];
  int unsigned nodes_used;
  out_item_t   answer_q[$];
  int unsigned fail_tally;

  function automatic int unsigned trie_child(int unsigned node, logic b);
    return b ? one_link[node] : zero_link[node];
  endfunction

  // Applies one command to the shadow trie and returns the answer it must produce.
  function automatic out_item_t trie_answer(in_item_t it);
    logic [127:0] addr;
    int unsigned  node;
    int unsigned  nxt;
    int unsigned  steps;
    int unsigned  best;
    logic         b;
    out_item_t    r;
    addr        = {it.addr_high, it.addr_low};
    r.match_len = '0;
    r.status    = STATUS_DONE;
    if (addr[127 -: ADDR_BITS] == '0) return r;
    node = 0;
    if (it.kind == KIND_INSERT) begin
      steps = (it.prefix_len > ADDR_BITS) ? ADDR_BITS : it.prefix_len;
      for (int p = 0; p < steps; p++) begin
        b   = addr[127 - p];
        nxt = trie_child(node, b);
        if (nxt == 0) begin
          if (nodes_used >= NODE_COUNT) begin
            r.status = STATUS_FULL;
            return r;
          end
          nxt = nodes_used;
          nodes_used++;
          zero_link[nxt]  = 0;
          one_link[nxt]   = 0;
          prefix_end[nxt] = 1'b0;
          if (b) one_link[node] = nxt;
          else zero_link[node] = nxt;
        end
        node = nxt;
      end
      prefix_end[node] = 1'b1;
    end else begin
      best = 0;
      for (int p = 0; p < ADDR_BITS; p++) begin
        nxt = trie_child(node, addr[127 - p]);
        if (nxt == 0) break;
        node = nxt;
        if (prefix_end[node]) best = p + 1;
      end
      r.match_len = best[7:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      nodes_used    = 1;
      zero_link[0]  = 0;
      one_link[0]   = 0;
      prefix_end[0] = 1'b0;
      fail_tally    = 0;
      answer_q.delete();
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: match_len %0d status %0d",
                 out_item.match_len, out_item.status);
          fail_tally++;
        end else begin
          want = answer_q.pop_front();
          if (out_item.match_len !== want.match_len) begin
            $error("match_len: expected %0d, actual %0d", want.match_len, out_item.match_len);
            fail_tally++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            fail_tally++;
          end
        end
      end
      if (start && !busy) answer_q.push_back(trie_answer(in_item));
    end
    mismatches   <= fail_tally;
    answers_owed <= answer_q.size();
  end

endmodule

### dv/binary_trie_prefix_match_tb.sv
// Testbench top for the binary trie prefix match block: stimulus, watchdog and verdict.
module binary_trie_prefix_match_tb;
  import btpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A walk visits at most ADDR_BITS levels and two more commands can queue behind it,
  // so reaching IDLE_LIMIT without any transfer can only mean a hang.
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned answers_owed;

  // Recently stored prefixes; random traffic branches off them so that walks go deep.
  logic [127:0] stored_addr[$];
  int unsigned  burst_left;

  binary_trie_prefix_match dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  trie_match_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .answers_owed(answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Keeps the leading keep bits of a and fills the rest with random bits.
  function automatic logic [127:0] tail_mix(logic [127:0] a, int unsigned keep);
    logic [127:0] keep_mask;
    logic [127:0] noise;
    noise     = {$urandom, $urandom, $urandom, $urandom};
    keep_mask = (keep == 0) ? '0 : ~({128{1'b1}} >> keep);
    return (a & keep_mask) | (noise & ~keep_mask);
  endfunction

  // Drives one command and holds it until the block takes the transfer. The sender then
  // either keeps start high for the next command of the burst or drops it for a gap.
  // Start is only lowered when a real gap follows, so it never gets two updates in one step.
  task automatic transfer(input logic kind, input logic [127:0] addr, input logic [7:0] plen);
    in_item_t    it;
    int unsigned gap;
    int unsigned roll;
    it.kind       = kind;
    it.addr_high  = addr[127:64];
    it.addr_low   = addr[63:0];
    it.prefix_len = plen;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (kind == KIND_INSERT && addr != '0 && plen != 0) begin
      stored_addr.push_back(addr);
      if (stored_addr.size() > 48) void'(stored_addr.pop_front());
    end
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 3) gap = 0;
      else if (roll < 9) gap = $urandom_range(1, 10);
      else gap = $urandom_range(20, 60);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // The watchdog ends the run when no command and no result has been transferred
  // for too long. Cycles under reset do not count.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [127:0] base;
    logic [127:0] addr;
    logic [7:0]   plen;
    int unsigned  roll;
    int unsigned  len_roll;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The trie starts empty, so the early lookups must miss.
    transfer(KIND_LOOKUP, '1, 8'd0);
    transfer(KIND_LOOKUP, '0, 8'd128);
    // An all-zero address is ignored on insert, whatever the length.
    transfer(KIND_INSERT, '0, 8'd128);
    // A zero length marks only the root, and the root's mark is never reported.
    transfer(KIND_INSERT, {64'h8000_0000_0000_0000, 64'h0}, 8'd0);
    transfer(KIND_LOOKUP, {64'h8000_0000_0000_0000, 64'h0}, 8'd0);
    transfer(KIND_INSERT, {64'h8000_0000_0000_0000, 64'h0}, 8'd1);
    transfer(KIND_LOOKUP, {64'hC000_0000_0000_0000, 64'h0}, 8'd255);
    // Lengths past the address width saturate to a full-depth prefix.
    transfer(KIND_INSERT, '1, 8'd255);
    transfer(KIND_LOOKUP, '1, 8'd0);
    transfer(KIND_INSERT, '1, 8'd128);
    transfer(KIND_LOOKUP, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE}, 8'd0);
    // A zero upper half is walked as 64 zero bits, not skipped; likewise a zero lower half.
    transfer(KIND_INSERT, {64'h0, 64'h1}, 8'd128);
    transfer(KIND_LOOKUP, {64'h0, 64'h1}, 8'd0);
    transfer(KIND_LOOKUP, {64'h0, 64'h2}, 8'd0);
    transfer(KIND_INSERT, {64'h1, 64'h0}, 8'd128);
    transfer(KIND_LOOKUP, {64'h1, 64'h0}, 8'd0);
    // Prefixes that end right at and right after the boundary of the two halves.
    transfer(KIND_INSERT, {64'hFFFF_0000_0000_0000, 64'h0}, 8'd64);
    transfer(KIND_INSERT, {64'hFFFF_0000_0000_0000, 64'h8000_0000_0000_0000}, 8'd65);
    transfer(KIND_LOOKUP, {64'hFFFF_0000_0000_0000, 64'h8000_0000_0000_1234}, 8'd0);
    transfer(KIND_LOOKUP, {64'hFFFF_0000_0000_0000, 64'h7FFF_0000_0000_0000}, 8'd0);
    // Zero paths now exist, yet an all-zero lookup must still answer no match.
    transfer(KIND_LOOKUP, '0, 8'd0);
    transfer(KIND_INSERT, {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555}, 8'd127);
    transfer(KIND_LOOKUP, {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5554}, 8'd0);
    transfer(KIND_LOOKUP, {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555}, 8'd0);

    // Random part. Most traffic branches off stored prefixes at a random depth; late
    // inserts are all long so that the node pool runs out and full status shows up.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (stored_addr.size() == 0) base = tail_mix('0, 0);
      else base = stored_addr[$urandom_range(0, stored_addr.size() - 1)];
      if (roll < 45) begin
        len_roll = $urandom_range(0, 99);
        if (i >= 700 || len_roll < 20) plen = 8'($urandom_range(25, 128));
        else if (len_roll < 28) plen = 8'($urandom_range(129, 255));
        else if (len_roll < 30) plen = 8'd0;
        else plen = 8'($urandom_range(1, 24));
        if ($urandom_range(0, 3) == 0) addr = tail_mix(base, 0);
        else addr = tail_mix(base, $urandom_range(0, (plen > 128) ? 128 : plen));
        transfer(KIND_INSERT, addr, plen);
      end else if (roll < 90) begin
        transfer(KIND_LOOKUP, tail_mix(base, $urandom_range(0, 128)),
                 8'($urandom_range(0, 255)));
      end else if (roll < 95) begin
        transfer(KIND_LOOKUP, tail_mix('0, 0), 8'($urandom_range(0, 255)));
      end else begin
        // Sparse addresses: all zero or a single set bit, with either command.
        addr = ($urandom_range(0, 2) == 0) ? '0 : (128'h1 << $urandom_range(0, 127));
        transfer(logic'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
      end
    end

    // Drain: wait until every expected answer has been transferred, then give the
    // block time to show any stray result.
    if (start) start <= 1'b0;
    do @(posedge clk); while (answers_owed != 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### binary_trie_prefix_match.f
+incdir+rtl
rtl/btpm_pkg.sv
rtl/btpm_front.sv
rtl/btpm_back.sv
rtl/binary_trie_prefix_match.sv
rtl/btpm_checker.sv
dv/trie_match_checker.sv
dv/binary_trie_prefix_match_tb.sv
